FILE: hw/rtl/ready_queue_cpu_scheduler_macros.svh
// Assertion macros for the ready queue scheduler.
`ifndef READY_QUEUE_CPU_SCHEDULER_MACROS_SVH
`define READY_QUEUE_CPU_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define RQS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rqs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rqs assertion failed");

`else

`define RQS_ASSERT_NOW(label, clk, rst, ante, cons)
`define RQS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/rqs_pkg.sv
// Types and constants of the ready queue scheduler.
package rqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int PID_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int STAMP_W = 32;
  localparam int WAIT_W  = 5;
  localparam int QUANT_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [ADDR_W-1:0]  ADDR_POLICY  = 3'd0;
  localparam logic [ADDR_W-1:0]  ADDR_QUANTUM = 3'd4;
  localparam logic [QUANT_W-1:0] QUANTUM_RST  = 16'd2;

  localparam logic ACT_ENQUEUE  = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    KIND_SLICE = 2'd0,
    KIND_IDLE  = 2'd1,
    KIND_ENQ   = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_PRIO = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LAST,
    S_SEL
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0]          pid;
    logic [BURST_W-1:0]        burst;
    logic signed [PRIO_W-1:0]  prio;
    logic [STAMP_W-1:0]        stamp;
  } entry_t;

endpackage

FILE: hw/rtl/rqs_req_if.sv
// Request channel: enqueue and dispatch transactions.
interface rqs_req_if import rqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [PID_W-1:0]         proc_id;
  logic [BURST_W-1:0]       proc_burst;
  logic signed [PRIO_W-1:0] proc_priority;

  modport source(output valid, action, proc_id, proc_burst, proc_priority, input ready);
  modport sink(input valid, action, proc_id, proc_burst, proc_priority, output ready);
endinterface

FILE: hw/rtl/rqs_rsp_if.sv
// Response channel: one result transaction per request.
interface rqs_rsp_if import rqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic [PID_W-1:0]         slice_id;
  logic [BURST_W-1:0]       executed;
  logic [BURST_W-1:0]       remaining;
  logic signed [PRIO_W-1:0] slice_priority;
  logic                     finished;
  logic [WAIT_W-1:0]        waiting;

  modport source(output valid, kind, slice_id, executed, remaining, slice_priority,
                 finished, waiting, input ready);
  modport sink(input valid, kind, slice_id, executed, remaining, slice_priority,
               finished, waiting, output ready);
endinterface

FILE: hw/rtl/ready_queue_cpu_scheduler.sv
// Ready queue scheduler top level: entry memory, selection scan and result register.
//
//   channel  dir  transaction
//   req      in   enqueue a process, or dispatch one slice
//   rsp      out  slice, idle, enqueued or rejected, plus store occupancy
//   apb      in   policy (0x0), time_quantum (0x4)
//
// Enqueue, idle and held-process dispatch are decided in the decode state.
// Dispatch from the store scans the entry memory through its single read port,
// one entry per cycle, then picks the winner in the last and select states.
// Synchronous reset clears valid bits, counters and the held process; no clearing pass.
// A full result register stalls the block in its deciding state, nothing changes meanwhile.
`include "ready_queue_cpu_scheduler_macros.svh"

module ready_queue_cpu_scheduler import rqs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rqs_req_if.sink           req,
  rqs_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration
  policy_t             policy;
  logic [QUANT_W-1:0]  quantum;
  logic [BURST_W-1:0]  q_eff;

  // control state
  state_t              state, state_next;
  logic [QUEUE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]    count;
  logic [STAMP_W-1:0]  arrival;
  logic                run_active;
  logic [PID_W-1:0]    run_pid;
  logic [BURST_W-1:0]  run_burst;
  logic signed [PRIO_W-1:0] run_prio;

  // captured request
  logic                   cur_action;
  logic [PID_W-1:0]       cur_pid;
  logic [BURST_W-1:0]     cur_burst;
  logic signed [PRIO_W-1:0] cur_prio;

  // entry memory
  entry_t              mem [QUEUE_DEPTH];
  entry_t              rd_data;
  logic                rd_en;
  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    scan_idx;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;

  // scan result
  entry_t              best;
  logic [IDX_W-1:0]    best_idx;
  logic                have_best;
  logic                cand_better;
  logic                cand_older;
  logic                scan_start;

  // free slot
  logic [IDX_W-1:0]    free_idx;

  // result register
  logic                out_valid;
  logic                out_free;
  logic                load_out;
  kind_t               res_kind;
  logic [PID_W-1:0]    res_id;
  logic [BURST_W-1:0]  res_exec;
  logic [BURST_W-1:0]  res_rem;
  logic signed [PRIO_W-1:0] res_prio;
  logic [WAIT_W-1:0]   res_wait;

  // side effects
  logic                valid_set;
  logic                valid_clr;
  logic [IDX_W-1:0]    valid_idx;
  logic                count_inc;
  logic                count_dec;
  logic                arrival_inc;
  logic                run_load;
  logic                run_step;
  logic [BURST_W-1:0]  run_burst_next;

  logic [BURST_W-1:0]  slice_burst;
  logic [BURST_W-1:0]  slice_exec;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= POL_FCFS;
      quantum <= QUANTUM_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_POLICY) begin
        policy <= policy_t'(pwdata[1:0]);
      end else if (paddr == ADDR_QUANTUM) begin
        quantum <= pwdata[QUANT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_POLICY) begin
      prdata = DATA_W'(policy);
    end else if (paddr == ADDR_QUANTUM) begin
      prdata = DATA_W'(quantum);
    end
  end

  assign q_eff = (quantum == '0) ? BURST_W'(1) : quantum;

  // ---------------------------------------------------------------- handshake
  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cur_action <= req.action;
      cur_pid    <= req.proc_id;
      cur_burst  <= req.proc_burst;
      cur_prio   <= req.proc_priority;
    end
  end

  // ---------------------------------------------------------------- free slot
  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // ---------------------------------------------------------------- memory
  assign rd_en = (state == S_SCAN);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (scan_start) begin
      scan_idx <= '0;
    end else if (rd_en) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // ---------------------------------------------------------------- selection
  assign cand_older = rd_data.stamp < best.stamp;

  always_comb begin
    unique case (policy)
      POL_SJF: begin
        cand_better = (rd_data.burst < best.burst) ||
                      ((rd_data.burst == best.burst) && cand_older);
      end
      POL_PRIO: begin
        cand_better = (rd_data.prio < best.prio) ||
                      ((rd_data.prio == best.prio) && cand_older);
      end
      POL_FCFS, POL_RR: begin
        cand_better = cand_older;
      end
      default: begin
        cand_better = cand_older;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (scan_start) begin
      have_best <= 1'b0;
    end else if (rd_vld && valid[rd_idx] && (!have_best || cand_better)) begin
      have_best <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && valid[rd_idx] && (!have_best || cand_better)) begin
      best     <= rd_data;
      best_idx <= rd_idx;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    slice_burst = (state == S_SEL) ? best.burst : run_burst;
    slice_exec  = (slice_burst > q_eff) ? q_eff : slice_burst;
    if ((state == S_SEL) && (policy == POL_FCFS)) begin
      slice_exec = slice_burst;
    end
  end

  always_comb begin
    state_next     = state;
    load_out       = 1'b0;
    res_kind       = KIND_SLICE;
    res_id         = '0;
    res_exec       = '0;
    res_rem        = '0;
    res_prio       = '0;
    res_wait       = WAIT_W'(count);
    mem_we         = 1'b0;
    mem_waddr      = free_idx;
    mem_wdata      = '{pid: cur_pid, burst: cur_burst, prio: cur_prio, stamp: arrival};
    valid_set      = 1'b0;
    valid_clr      = 1'b0;
    valid_idx      = free_idx;
    count_inc      = 1'b0;
    count_dec      = 1'b0;
    arrival_inc    = 1'b0;
    run_load       = 1'b0;
    run_step       = 1'b0;
    run_burst_next = slice_burst - slice_exec;
    scan_start     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        if (cur_action == ACT_ENQUEUE) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
            if (count >= CNT_W'(QUEUE_DEPTH)) begin
              res_kind = KIND_FULL;
            end else begin
              res_kind    = KIND_ENQ;
              res_wait    = WAIT_W'(count + 1'b1);
              mem_we      = 1'b1;
              valid_set   = 1'b1;
              count_inc   = 1'b1;
              arrival_inc = 1'b1;
            end
          end
        end else if (run_active) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
            res_id     = run_pid;
            res_exec   = slice_exec;
            res_rem    = run_burst_next;
            res_prio   = run_prio;
            run_step   = 1'b1;
          end
        end else if (count == '0) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
            res_kind   = KIND_IDLE;
          end
        end else begin
          scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_idx == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_next = S_LAST;
        end
      end

      S_LAST: begin
        state_next = S_SEL;
      end

      S_SEL: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          res_id     = best.pid;
          res_exec   = slice_exec;
          res_rem    = run_burst_next;
          res_prio   = best.prio;
          if ((policy == POL_RR) && (run_burst_next != '0)) begin
            mem_we      = 1'b1;
            mem_waddr   = best_idx;
            mem_wdata   = '{pid: best.pid, burst: run_burst_next, prio: best.prio,
                            stamp: arrival};
            arrival_inc = 1'b1;
          end else begin
            valid_clr = 1'b1;
            valid_idx = best_idx;
            count_dec = 1'b1;
            res_wait  = WAIT_W'(count - 1'b1);
            run_load  = (run_burst_next != '0);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      count   <= '0;
      arrival <= '0;
    end else begin
      if (valid_set) begin
        valid[valid_idx] <= 1'b1;
      end else if (valid_clr) begin
        valid[valid_idx] <= 1'b0;
      end
      if (count_inc) begin
        count <= count + 1'b1;
      end else if (count_dec) begin
        count <= count - 1'b1;
      end
      if (arrival_inc) begin
        arrival <= arrival + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      run_pid    <= '0;
      run_burst  <= '0;
      run_prio   <= '0;
    end else if (run_load) begin
      run_active <= 1'b1;
      run_pid    <= best.pid;
      run_burst  <= run_burst_next;
      run_prio   <= best.prio;
    end else if (run_step) begin
      run_burst <= run_burst_next;
      if (run_burst_next == '0) begin
        run_active <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.kind           <= res_kind;
      rsp.slice_id       <= res_id;
      rsp.executed       <= res_exec;
      rsp.remaining      <= res_rem;
      rsp.slice_priority <= res_prio;
      rsp.finished       <= (res_kind == KIND_SLICE) && (res_rem == '0);
      rsp.waiting        <= res_wait;
    end
  end

  assign rsp.valid = out_valid;

  // ---------------------------------------------------------------- checks
  `RQS_ASSERT_NOW(a_count_matches_valid, clk, rst, 1'b1, count == $countones(valid))
  `RQS_ASSERT_NOW(a_held_has_burst, clk, rst, run_active, run_burst != '0)
  `RQS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, req.valid && req.ready, state != S_IDLE)
  `RQS_ASSERT_NOW(a_select_found, clk, rst, state == S_SEL, have_best)

endmodule

FILE: bench/ready_queue_cpu_scheduler_tb.sv
// Self-checking testbench for the ready queue scheduler: directed, back-pressure and random tests.
`timescale 1ns / 1ps

module ready_queue_cpu_scheduler_tb import rqs_pkg::*; ();

  typedef struct packed {
    kind_t                    kind;
    logic [PID_W-1:0]         slice_id;
    logic [BURST_W-1:0]       executed;
    logic [BURST_W-1:0]       remaining;
    logic signed [PRIO_W-1:0] slice_priority;
    logic                     finished;
    logic [WAIT_W-1:0]        waiting;
  } sched_outcome_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rqs_req_if req_ch ();
  rqs_rsp_if rsp_ch ();

  ready_queue_cpu_scheduler u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the ready queue
  logic                     slot_used  [QUEUE_DEPTH];
  logic [PID_W-1:0]         slot_pid   [QUEUE_DEPTH];
  logic [BURST_W-1:0]       slot_burst [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] slot_prio  [QUEUE_DEPTH];
  logic [STAMP_W-1:0]       slot_stamp [QUEUE_DEPTH];
  logic [STAMP_W-1:0]       arrivals;
  int                       occupancy;
  logic                     held;
  logic [PID_W-1:0]         held_pid;
  logic [BURST_W-1:0]       held_burst;
  logic signed [PRIO_W-1:0] held_prio;
  policy_t                  cur_policy;
  logic [QUANT_W-1:0]       cur_quantum;

  sched_outcome_t due_outcomes[$];

  logic req_hot;
  logic idle_on;
  int   hold_left;
  int   fail_count;
  int   n_sent;
  int   n_slices;
  int   n_idle;
  int   n_enq;
  int   n_full;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("ready_queue_cpu_scheduler verification failed");
    $finish;
  end

  function automatic sched_outcome_t decide_outcome(input logic act,
                                                    input logic [PID_W-1:0] id,
                                                    input logic [BURST_W-1:0] burst,
                                                    input logic signed [PRIO_W-1:0] prio);
    sched_outcome_t     r;
    int                 sel;
    logic               older;
    logic               better;
    logic [BURST_W-1:0] q;
    logic [BURST_W-1:0] run;
    logic [BURST_W-1:0] left;
    r = '0;
    q = (cur_quantum == '0) ? 16'd1 : cur_quantum;
    if (act == ACT_ENQUEUE) begin
      if (occupancy >= QUEUE_DEPTH) begin
        r.kind = KIND_FULL;
        n_full++;
      end else begin
        sel = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!slot_used[i] && sel < 0) sel = i;
        end
        slot_used[sel]  = 1'b1;
        slot_pid[sel]   = id;
        slot_burst[sel] = burst;
        slot_prio[sel]  = prio;
        slot_stamp[sel] = arrivals;
        arrivals++;
        occupancy++;
        r.kind = KIND_ENQ;
        n_enq++;
      end
    end else if (held) begin
      run  = (held_burst > q) ? q : held_burst;
      left = held_burst - run;
      r.kind           = KIND_SLICE;
      r.slice_id       = held_pid;
      r.executed       = run;
      r.remaining      = left;
      r.slice_priority = held_prio;
      r.finished       = (left == '0);
      held_burst = left;
      if (left == '0) held = 1'b0;
      n_slices++;
    end else if (occupancy == 0) begin
      r.kind = KIND_IDLE;
      n_idle++;
    end else begin
      sel = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (slot_used[i]) begin
          if (sel < 0) begin
            sel = i;
          end else begin
            older = slot_stamp[i] < slot_stamp[sel];
            case (cur_policy)
              POL_SJF: begin
                better = (slot_burst[i] < slot_burst[sel]) ||
                         (slot_burst[i] == slot_burst[sel] && older);
              end
              POL_PRIO: begin
                better = (slot_prio[i] < slot_prio[sel]) ||
                         (slot_prio[i] == slot_prio[sel] && older);
              end
              default: begin
                better = older;
              end
            endcase
            if (better) sel = i;
          end
        end
      end
      if (cur_policy == POL_FCFS) begin
        run  = slot_burst[sel];
        left = '0;
      end else begin
        run  = (slot_burst[sel] > q) ? q : slot_burst[sel];
        left = slot_burst[sel] - run;
      end
      r.kind           = KIND_SLICE;
      r.slice_id       = slot_pid[sel];
      r.executed       = run;
      r.remaining      = left;
      r.slice_priority = slot_prio[sel];
      r.finished       = (left == '0);
      n_slices++;
      if (cur_policy == POL_RR && left != '0) begin
        // back to the tail: new stamp, same slot
        slot_burst[sel] = left;
        slot_stamp[sel] = arrivals;
        arrivals++;
      end else begin
        if (left != '0) begin
          held       = 1'b1;
          held_pid   = slot_pid[sel];
          held_burst = left;
          held_prio  = slot_prio[sel];
        end
        slot_used[sel] = 1'b0;
        occupancy--;
      end
    end
    r.waiting = occupancy[WAIT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%h, got 0x%h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    sched_outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_outcomes.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fail_count++;
      end else begin
        want = due_outcomes.pop_front();
        check_field("kind", 16'(want.kind), 16'(rsp_ch.kind));
        check_field("slice_id", want.slice_id, rsp_ch.slice_id);
        check_field("executed", want.executed, rsp_ch.executed);
        check_field("remaining", want.remaining, rsp_ch.remaining);
        check_field("slice_priority", 16'(want.slice_priority),
                    16'(rsp_ch.slice_priority));
        check_field("finished", 16'(want.finished), 16'(rsp_ch.finished));
        check_field("waiting", 16'(want.waiting), 16'(rsp_ch.waiting));
      end
    end
  end

  // Result side: random stall per transaction plus an optional long hold-off
  initial begin
    int   stall_left;
    logic nxt;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) stall_left = idle_on ? $urandom_range(0, 19) : 0;
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      rsp_ch.ready <= nxt;
    end
  end

  task automatic req_quiet();
    if (req_hot) begin
      req_ch.valid <= 1'b0;
      req_hot = 1'b0;
    end
  endtask

  task automatic send_request(input logic act, input logic [PID_W-1:0] id,
                              input logic [BURST_W-1:0] burst,
                              input logic signed [PRIO_W-1:0] prio);
    int             gap;
    sched_outcome_t outcome;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_quiet();
      repeat (gap) @(posedge clk);
    end
    if (!req_hot) begin
      req_ch.valid <= 1'b1;
      req_hot = 1'b1;
    end
    req_ch.action        <= act;
    req_ch.proc_id       <= id;
    req_ch.proc_burst    <= burst;
    req_ch.proc_priority <= prio;
    do @(posedge clk); while (!req_ch.ready);
    outcome      = decide_outcome(act, id, burst, prio);
    due_outcomes = {due_outcomes, outcome};
    n_sent++;
  endtask

  task automatic dispatch();
    send_request(ACT_DISPATCH, PID_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic wait_drained();
    req_quiet();
    while (due_outcomes.size() != 0) @(posedge clk);
  endtask

  // Write then read back over APB; block must be idle
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    wait_drained();
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_POLICY) cur_policy = policy_t'(data[1:0]);
    else cur_quantum = data[QUANT_W-1:0];
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_POLICY) check_field("policy", 16'(cur_policy), 16'(prdata[1:0]));
    else check_field("time_quantum", cur_quantum, prdata[QUANT_W-1:0]);
  endtask

  function automatic logic [BURST_W-1:0] draw_burst();
    if ((cur_policy == POL_FCFS || cur_quantum >= 16'h1000) && $urandom_range(0, 3) == 0)
      return BURST_W'($urandom);
    return BURST_W'($urandom_range(0, 12));
  endfunction

  // Empty dispatch, fill to the brim, rejection, FCFS incl. zero burst
  task automatic test_empty_and_full();
    logic [PID_W-1:0]         id;
    logic [BURST_W-1:0]       burst;
    logic signed [PRIO_W-1:0] prio;
    idle_on = 1'b1;
    dispatch();
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      id    = (i == 0) ? '0 : (i == 1) ? '1 : PID_W'($urandom);
      burst = (i == 0) ? '0 : (i == 1) ? '1 : BURST_W'($urandom_range(1, 4));
      prio  = (i == 0) ? -8'sd128 : (i == 1) ? 8'sd127 : PRIO_W'($urandom_range(0, 2) - 1);
      send_request(ACT_ENQUEUE, id, burst, prio);
    end
    dispatch();
    dispatch();
  endtask

  // Each policy in turn, ties, quantum extremes, held process across a policy change
  task automatic test_policy_selection();
    write_reg(ADDR_POLICY, 32'(POL_RR));
    write_reg(ADDR_QUANTUM, 32'd0);
    dispatch();
    dispatch();
    send_request(ACT_ENQUEUE, 16'h1234, 16'd9, -8'sd3);
    write_reg(ADDR_POLICY, 32'(POL_SJF));
    write_reg(ADDR_QUANTUM, 32'd3);
    repeat (3) dispatch();
    write_reg(ADDR_POLICY, 32'(POL_PRIO));
    dispatch();
    write_reg(ADDR_POLICY, 32'(POL_FCFS));
    repeat (2) dispatch();
    write_reg(ADDR_POLICY, 32'(POL_PRIO));
    write_reg(ADDR_QUANTUM, 32'hFFFF);
    repeat (3) dispatch();
  endtask

  // Receiver holds off while the sender floods: the block must stall its input
  task automatic test_backpressure();
    wait_drained();
    idle_on   = 1'b0;
    hold_left = 400;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) dispatch();
      else send_request(ACT_ENQUEUE, PID_W'($urandom), draw_burst(), PRIO_W'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_random_mix();
    int  enq_pct;
    logic big_ok;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(ADDR_POLICY, 32'(ph % 4));
      case (ph % 6)
        0: write_reg(ADDR_QUANTUM, 32'd1);
        1: write_reg(ADDR_QUANTUM, 32'hFFFF);
        2: write_reg(ADDR_QUANTUM, 32'd0);
        3: write_reg(ADDR_QUANTUM, 32'd3);
        4: write_reg(ADDR_QUANTUM, 32'($urandom_range(1, 8)));
        default: write_reg(ADDR_QUANTUM, 32'($urandom_range(0, 16'hFFFF)));
      endcase
      idle_on = (ph % 3 != 2);
      enq_pct = (ph % 3 == 0) ? 70 : (ph % 3 == 1) ? 35 : 55;
      big_ok  = (cur_policy == POL_FCFS || cur_quantum >= 16'h1000);
      for (int k = 0; k < 65; k++) begin
        if ($urandom_range(0, 99) < enq_pct)
          send_request(ACT_ENQUEUE, PID_W'($urandom), draw_burst(), PRIO_W'($urandom));
        else
          dispatch();
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      // long bursts must not outlive a large quantum
      if (big_ok) begin
        while (occupancy > 0 || held) dispatch();
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_ch.valid  = 1'b0;
    req_ch.action = ACT_ENQUEUE;
    req_ch.proc_id       = '0;
    req_ch.proc_burst    = '0;
    req_ch.proc_priority = '0;
    req_hot     = 1'b0;
    idle_on     = 1'b1;
    hold_left   = 0;
    fail_count  = 0;
    n_sent      = 0;
    n_slices    = 0;
    n_idle      = 0;
    n_enq       = 0;
    n_full      = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) slot_used[i] = 1'b0;
    arrivals    = '0;
    occupancy   = 0;
    held        = 1'b0;
    held_pid    = '0;
    held_burst  = '0;
    held_prio   = '0;
    cur_policy  = POL_FCFS;
    cur_quantum = QUANTUM_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_full();
    test_policy_selection();
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (QUEUE_DEPTH + 8) @(posedge clk);
    $display("run covered %0d request transactions under all four policies", n_sent);
    $display("results: %0d slices, %0d idle, %0d enqueued, %0d rejected",
             n_slices, n_idle, n_enq, n_full);
    if (fail_count == 0) begin
      $display("ready_queue_cpu_scheduler verification clean");
    end else begin
      $display("ready_queue_cpu_scheduler verification failed");
    end
    $finish;
  end

endmodule
